[rtl/four_digit_seven_segment_scanner_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define FDSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent overlaps consequent.
`define FDSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    `FDSS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication form: consequent in the cycle after the antecedent.
`define FDSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `FDSS_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/fdss_pkg.sv]
`timescale 1ns / 1ps
package fdss_pkg;

    localparam int unsigned C_VALUE_W = 16;
    localparam int unsigned C_REM_W   = 14;
    localparam int unsigned C_DIGIT_W = 4;
    localparam int unsigned C_NUM_POS = 4;
    localparam int unsigned C_POS_W   = 2;
    localparam int unsigned C_SEG_W   = 8;

    localparam logic [C_VALUE_W-1:0] C_MAX_VALUE = 16'd9999;

    localparam logic [C_POS_W-1:0] C_POS_ONES      = 2'd0;
    localparam logic [C_POS_W-1:0] C_POS_TENS      = 2'd1;
    localparam logic [C_POS_W-1:0] C_POS_HUNDREDS  = 2'd2;
    localparam logic [C_POS_W-1:0] C_POS_THOUSANDS = 2'd3;

    localparam logic [C_SEG_W-1:0] C_SEG_DP    = 8'h80;
    localparam logic [C_SEG_W-1:0] C_SEG_MINUS = 8'h40;
    localparam logic [C_SEG_W-1:0] C_SEG_BLANK = 8'h00;

    typedef logic [C_DIGIT_W-1:0] t_digit;
    typedef t_digit [C_NUM_POS-1:0] t_digits;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef enum logic {
        CONV_IDLE,
        CONV_RUN
    } t_conv_state;

    typedef struct packed {
        logic    busy;
        t_digits digits;
    } t_conv_status;

    function automatic logic [C_REM_W-1:0] place_weight(input logic [C_POS_W-1:0] pos);
        logic [C_REM_W-1:0] w;
        unique case (pos)
            C_POS_THOUSANDS: w = 14'd1000;
            C_POS_HUNDREDS:  w = 14'd100;
            C_POS_TENS:      w = 14'd10;
            default:         w = 14'd1;
        endcase
        return w;
    endfunction

    function automatic logic [C_SEG_W-1:0] glyph(input t_digit d);
        logic [C_SEG_W-1:0] g;
        unique case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = C_SEG_MINUS;
        endcase
        return g;
    endfunction

endpackage

[rtl/four_digit_seven_segment_scanner_core.sv]
`timescale 1ns / 1ps
// Four-digit multiplexed seven-segment scanner.
// Input stream: s_axis_tuser selects the operation (0 = load, 1 = scan tick),
//   s_axis_tdata carries the 16-bit value used by a load.
// Output stream: one transfer per tick; m_axis_tdata = segments a..g + dp in
//   bits 7:0, one-hot digit enable in bits 11:8 (ones .. thousands).
// A load produces no output. It runs a repeated-subtraction conversion in a
//   shared subtractor, one subtraction per cycle, with s_axis_tready low
//   meanwhile. Values above 9999 show 0.
// A tick reads the digit store and drives the output register on the next
//   cycle; ticks can be taken every cycle while no conversion runs and the output side keeps up.
// The scan steps ones, tens, hundreds, thousands and wraps. The hundreds
//   digit carries the decimal point; a zero thousands digit is blanked.
// Reset clears the digit store to zeros, the scan to the ones position and
//   the output register to empty.
// When m_axis_tready is low, the pending result holds and s_axis_tready
//   drops until it is taken.
module four_digit_seven_segment_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] value
    input  logic [0:0]  s_axis_tuser,  // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // [7:0] segments, [11:8] digit_enable, [15:12] zero
);
    import fdss_pkg::*;

    t_conv_status          w_status;
    logic                  w_accept;
    logic                  w_tick;
    logic                  w_load;
    logic [C_SEG_W-1:0]    w_seg;
    logic [C_NUM_POS-1:0]  w_enable;

    logic [C_POS_W-1:0]    r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [C_SEG_W-1:0]    r_out_seg, n_out_seg;
    logic [C_NUM_POS-1:0]  r_out_en, n_out_en;

    assign s_axis_tready = !w_status.busy && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_tick        = w_accept && (t_func'(s_axis_tuser[0]) == FUNC_TICK);
    assign w_load        = w_accept && (t_func'(s_axis_tuser[0]) == FUNC_LOAD);

    fdss_bcd_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_load),
        .i_value  (s_axis_tdata),
        .o_status (w_status)
    );

    fdss_seg_enc u_enc (
        .i_digits (w_status.digits),
        .i_pos    (r_pos),
        .o_seg    (w_seg),
        .o_enable (w_enable)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= C_POS_ONES;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
        r_out_seg <= n_out_seg;
        r_out_en  <= n_out_en;
    end

    always_comb begin
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out_seg   = r_out_seg;
        n_out_en    = r_out_en;
        if (w_tick) begin
            n_out_valid = 1'b1;
            n_out_seg   = w_seg;
            n_out_en    = w_enable;
            n_pos       = r_pos + 2'd1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_en, r_out_seg};

endmodule

[rtl/fdss_bcd_conv.sv]
`timescale 1ns / 1ps
module fdss_bcd_conv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fdss_pkg::C_VALUE_W-1:0] i_value,
    output fdss_pkg::t_conv_status        o_status
);
    import fdss_pkg::*;

    t_conv_state          r_state, n_state;
    t_digits              r_digits, n_digits;
    logic [C_REM_W-1:0]   r_rem, n_rem;
    t_digit               r_cnt, n_cnt;
    logic [C_POS_W-1:0]   r_place, n_place;
    logic [C_REM_W-1:0]   w_weight;

    assign w_weight = place_weight(r_place);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CONV_IDLE;
            r_digits <= '0;
        end else begin
            r_state  <= n_state;
            r_digits <= n_digits;
        end
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_place <= n_place;
    end

    // shared compare/subtract: one subtraction of the current place weight per cycle
    always_comb begin
        n_state  = r_state;
        n_digits = r_digits;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_place  = r_place;
        unique case (r_state)
            CONV_IDLE: begin
                if (i_start) begin
                    n_rem   = (i_value > C_MAX_VALUE) ? '0 : i_value[C_REM_W-1:0];
                    n_cnt   = '0;
                    n_place = C_POS_THOUSANDS;
                    n_state = CONV_RUN;
                end
            end
            CONV_RUN: begin
                if (r_rem >= w_weight) begin
                    n_rem = r_rem - w_weight;
                    n_cnt = r_cnt + 4'd1;
                end else begin
                    n_digits[r_place] = r_cnt;
                    n_cnt             = '0;
                    n_place           = r_place - 2'd1;
                    if (r_place == C_POS_TENS) begin
                        n_digits[C_POS_ONES] = r_rem[C_DIGIT_W-1:0];
                        n_state              = CONV_IDLE;
                    end
                end
            end
            default: n_state = CONV_IDLE;
        endcase
    end

    assign o_status.busy   = (r_state != CONV_IDLE);
    assign o_status.digits = r_digits;

endmodule

[rtl/fdss_seg_enc.sv]
`timescale 1ns / 1ps
module fdss_seg_enc (
    input  fdss_pkg::t_digits              i_digits,
    input  logic [fdss_pkg::C_POS_W-1:0]   i_pos,
    output logic [fdss_pkg::C_SEG_W-1:0]   o_seg,
    output logic [fdss_pkg::C_NUM_POS-1:0] o_enable
);
    import fdss_pkg::*;

    t_digit w_digit;

    assign w_digit = i_digits[i_pos];

    always_comb begin
        o_seg = glyph(w_digit);
        if (i_pos == C_POS_HUNDREDS) begin
            o_seg = o_seg | C_SEG_DP;
        end
        // leading zero blanking of the thousands digit only
        if (i_pos == C_POS_THOUSANDS && w_digit == '0) begin
            o_seg = C_SEG_BLANK;
        end
    end

    assign o_enable = C_NUM_POS'(1) << i_pos;

endmodule

[rtl/fdss_checker.sv]
`timescale 1ns / 1ps
`include "four_digit_seven_segment_scanner_core_defines.svh"
module fdss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    `FDSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

    `FDSS_ASSERT_IMPL(a_enable_onehot, i_clk, i_rst_n,
        m_axis_tvalid, $onehot(m_axis_tdata[11:8]), "digit enable not one-hot")

    `FDSS_ASSERT_IMPL(a_dp_hundreds, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[7] == m_axis_tdata[10],
        "decimal point not tied to hundreds position")

    `FDSS_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[15:12] == 4'b0, "output pad bits not zero")

    `FDSS_ASSERT_NEXT(a_tick_result, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0],
        m_axis_tvalid, "tick transfer gave no output transfer")

endmodule

bind four_digit_seven_segment_scanner_core fdss_checker u_fdss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
